// File: rtl/qgs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the quadruped gait sequencer.
package qgs_pkg;

    localparam int unsigned REQ_W   = 3;
    localparam int unsigned LEG_W   = 2;
    localparam int unsigned MV_W    = 3;
    localparam int unsigned WAIT_W  = 16;
    localparam int unsigned DIN_W   = 16;
    localparam int unsigned STEP_W  = 5;

    // ceil(2^17 / 3): exact reciprocal of 3 for operands below 2^17
    localparam int unsigned RECIP3_SHIFT = 17;
    localparam logic [16:0] RECIP3       = 17'd43691;

    typedef enum logic [REQ_W-1:0] {
        REQ_IDLE  = 3'd0,
        REQ_FWD   = 3'd1,
        REQ_REV   = 3'd2,
        REQ_LEFT  = 3'd3,
        REQ_RIGHT = 3'd4,
        REQ_ROT_L = 3'd5,
        REQ_ROT_R = 3'd6,
        REQ_BAD   = 3'd7
    } req_t;

    typedef enum logic [MV_W-1:0] {
        MV_COXA_UP   = 3'd0,
        MV_COXA_DOWN = 3'd1,
        MV_FEMUR_FWD = 3'd2,
        MV_FEMUR_BK  = 3'd3,
        MV_FEMUR_IDL = 3'd4,
        MV_SIDE_FWD  = 3'd5,
        MV_SIDE_BK   = 3'd6
    } mv_t;

    typedef enum logic [LEG_W-1:0] {
        LEG_FL = 2'd0,
        LEG_FR = 2'd1,
        LEG_BL = 2'd2,
        LEG_BR = 2'd3
    } leg_t;

    typedef struct packed {
        logic load;
        logic calc;
        logic emit;
    } qgs_cmd_t;

    typedef struct packed {
        logic final_step;
    } qgs_sts_t;

endpackage

// File: rtl/qgs_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: command intake, wait setup and step emission.
module qgs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  qgs_pkg::qgs_sts_t sts,
    output qgs_pkg::qgs_cmd_t cmd
);
    import qgs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.calc   = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.emit = 1'b1;
                    if (sts.final_step) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = cmd.emit | (out_valid_reg & ~m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    a_accept_to_prep: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_PREP))
        else $error("accepted beat did not start wait setup");

    a_final_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && sts.final_step) |=> (state_reg == ST_IDLE))
        else $error("run did not end after final step");

    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!out_valid_reg || m_tready))
        else $error("step emitted over a pending result");

endmodule

// File: rtl/qgs_datapath.sv
`timescale 1ns / 1ps
// Datapath: command registers, wait dividers, step counter and result register.
module qgs_datapath #(
    parameter int unsigned DELAY_WIDTH = 16
) (
    input  logic                          aclk,
    input  qgs_pkg::qgs_cmd_t             cmd,
    output qgs_pkg::qgs_sts_t             sts,
    input  logic [qgs_pkg::REQ_W-1:0]     in_req,
    input  logic [qgs_pkg::DIN_W-1:0]     in_delay,
    output logic [qgs_pkg::LEG_W-1:0]     out_leg,
    output logic [qgs_pkg::MV_W-1:0]      out_mv,
    output logic [qgs_pkg::WAIT_W-1:0]    out_wait,
    output logic                          out_bad,
    output logic                          out_last
);
    import qgs_pkg::*;

    localparam int unsigned DW = (DELAY_WIDTH < DIN_W) ? DELAY_WIDTH : DIN_W;
    localparam int unsigned XW = DW - 3;
    localparam int unsigned PW = XW + RECIP3_SHIFT;

    req_t              req_reg;
    logic [DW-1:0]     delay_reg;
    logic [DW-1:0]     short_reg, short_next;
    logic [DW-1:0]     half_reg, half_next;
    logic [STEP_W-1:0] step_reg;

    logic [XW-1:0]     div8;
    logic [PW-1:0]     prod;
    logic [XW-1:0]     q24;
    logic [DW-2:0]     q2;

    logic              fl, fr, side;
    logic [2:0]        j;
    logic              h;
    leg_t              l1, l2, s1, s2;
    logic [STEP_W-1:0] last_idx;

    leg_t              leg_c;
    mv_t               mv_c;
    logic [WAIT_W-1:0] wait_c;
    logic              bad_c;

    function automatic mv_t femur_pick(input leg_t leg, input logic lifted,
                                       input logic f_l, input logic f_r,
                                       input logic sd);
        logic prog, go;
        prog = leg[0] ? f_r : f_l;
        go   = (lifted == prog);
        if (sd) begin
            return go ? MV_SIDE_FWD : MV_SIDE_BK;
        end
        return go ? MV_FEMUR_FWD : MV_FEMUR_BK;
    endfunction

    // delay / 24 = (delay >> 3) / 3, divide by 3 through the reciprocal
    assign div8 = delay_reg[DW-1:3];
    assign prod = PW'(div8) * PW'(RECIP3);
    assign q24  = prod[PW-1:RECIP3_SHIFT];
    assign q2   = delay_reg[DW-1:1];

    always_comb begin
        short_next = DW'(q24);
        half_next  = DW'(q2);
        if (delay_reg != '0) begin
            if (q24 == '0) begin
                short_next = DW'(1);
            end
            if (q2 == '0) begin
                half_next = DW'(1);
            end
        end
    end

    assign fl   = (req_reg inside {REQ_FWD, REQ_LEFT, REQ_ROT_L});
    assign fr   = (req_reg inside {REQ_FWD, REQ_LEFT, REQ_ROT_R});
    assign side = (req_reg inside {REQ_LEFT, REQ_RIGHT, REQ_ROT_L, REQ_ROT_R});

    assign j  = step_reg[2:0];
    assign h  = step_reg[3];
    assign l1 = h ? LEG_FL : LEG_FR;
    assign l2 = h ? LEG_BR : LEG_BL;
    assign s1 = h ? LEG_FR : LEG_FL;
    assign s2 = h ? LEG_BL : LEG_BR;

    always_comb begin
        case (req_reg)
            REQ_IDLE:                       last_idx = STEP_W'(7);
            REQ_FWD, REQ_REV,
            REQ_LEFT, REQ_RIGHT:            last_idx = STEP_W'(15);
            REQ_ROT_L, REQ_ROT_R:           last_idx = STEP_W'(31);
            default:                        last_idx = '0;
        endcase
    end

    assign sts.final_step = (step_reg == last_idx);

    always_comb begin
        leg_c  = LEG_FL;
        mv_c   = MV_COXA_UP;
        wait_c = '0;
        bad_c  = 1'b0;
        case (req_reg)
            REQ_IDLE: begin
                leg_c = leg_t'(step_reg[2:1]);
                mv_c  = step_reg[0] ? MV_FEMUR_IDL : MV_COXA_DOWN;
            end
            REQ_BAD: begin
                bad_c = 1'b1;
            end
            default: begin
                case (j)
                    3'd0: begin
                        leg_c  = l1;
                        mv_c   = MV_COXA_UP;
                        wait_c = WAIT_W'(short_reg);
                    end
                    3'd1: begin
                        leg_c  = l2;
                        mv_c   = MV_COXA_UP;
                        wait_c = WAIT_W'(short_reg);
                    end
                    3'd2: begin
                        leg_c  = s1;
                        mv_c   = femur_pick(s1, 1'b0, fl, fr, side);
                        wait_c = WAIT_W'(short_reg);
                    end
                    3'd3: begin
                        leg_c  = s2;
                        mv_c   = femur_pick(s2, 1'b0, fl, fr, side);
                        wait_c = WAIT_W'(half_reg);
                    end
                    3'd4: begin
                        leg_c  = l1;
                        mv_c   = femur_pick(l1, 1'b1, fl, fr, side);
                        wait_c = WAIT_W'(short_reg);
                    end
                    3'd5: begin
                        leg_c  = l2;
                        mv_c   = femur_pick(l2, 1'b1, fl, fr, side);
                        wait_c = WAIT_W'(delay_reg);
                    end
                    3'd6: begin
                        leg_c  = l1;
                        mv_c   = MV_COXA_DOWN;
                        wait_c = WAIT_W'(short_reg);
                    end
                    default: begin
                        leg_c  = l2;
                        mv_c   = MV_COXA_DOWN;
                        wait_c = WAIT_W'(delay_reg);
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg   <= req_t'(in_req);
            delay_reg <= in_delay[DW-1:0];
            step_reg  <= '0;
        end
        if (cmd.calc) begin
            short_reg <= short_next;
            half_reg  <= half_next;
        end
        if (cmd.emit) begin
            step_reg <= step_reg + STEP_W'(1);
            out_leg  <= leg_c;
            out_mv   <= mv_c;
            out_wait <= wait_c;
            out_bad  <= bad_c;
            out_last <= sts.final_step & ~bad_c;
        end
    end

endmodule

// File: rtl/quadruped_gait_sequencer_top.sv
`timescale 1ns / 1ps
// Quadruped gait sequencer top level: stream ports, controller and datapath.
// An accepted command passes ST_PREP, then ST_RUN registers its first result beat.
// Throughput: one result beat per cycle unless m_tready stalls; a command has an ST_PREP setup
// then its run: 8 beats for idle, 16 for a walk, 32 for a rotation, 1 for a bad command.
// The step counter is the pacing element: one leg step leaves per clock unless stalled.
// Reset clears the state machine and the output valid; payload registers are not reset.
module quadruped_gait_sequencer_top #(
    parameter int unsigned DELAY_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] base_delay
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [1:0] leg_id, [4:2] movement, [20:5] wait_time, zero fill
    output logic        m_tuser,   // [0] bad_command
    output logic        m_tlast    // last_step
);
    import qgs_pkg::*;

    qgs_cmd_t          cmd;
    qgs_sts_t          sts;
    logic [LEG_W-1:0]  leg;
    logic [MV_W-1:0]   mv;
    logic [WAIT_W-1:0] wt;

    qgs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    qgs_datapath #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_dp (
        .aclk     (aclk),
        .cmd      (cmd),
        .sts      (sts),
        .in_req   (s_tuser),
        .in_delay (s_tdata),
        .out_leg  (leg),
        .out_mv   (mv),
        .out_wait (wt),
        .out_bad  (m_tuser),
        .out_last (m_tlast)
    );

    assign m_tdata = {3'b000, wt, mv, leg};

endmodule

// File: verif/quadruped_gait_sequencer_checker.sv
`timescale 1ns / 1ps
// Stream monitor for the gait sequencer: predicts each command's leg steps and checks result beats.
module quadruped_gait_sequencer_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          mismatches,
    output int          outstanding
);
    import qgs_pkg::*;

    typedef struct packed {
        leg_t        leg;
        mv_t         mv;
        logic [15:0] wait_ms;
        logic        bad;
        logic        last;
    } gait_step_t;

    gait_step_t steps_due[$];
    int         err_total = 0;
    int         due_count = 0;

    assign mismatches  = err_total;
    assign outstanding = due_count;

    function automatic logic [15:0] scaled_wait(logic [15:0] dly, int unsigned div);
        int unsigned q;
        q = dly / div;
        if (dly == 16'd0) return 16'd0;
        if (q == 0) return 16'd1;
        return q[15:0];
    endfunction

    function automatic mv_t femur_move(leg_t leg, bit lifted, bit fwd_l, bit fwd_r, bit side);
        bit prog_fwd;
        bit go_fwd;
        prog_fwd = (leg == LEG_FR || leg == LEG_BR) ? fwd_r : fwd_l;
        go_fwd   = (lifted == prog_fwd);
        if (side) return go_fwd ? MV_SIDE_FWD : MV_SIDE_BK;
        return go_fwd ? MV_FEMUR_FWD : MV_FEMUR_BK;
    endfunction

    function automatic void add_step(leg_t leg, mv_t mv, logic [15:0] w);
        steps_due.push_back('{leg, mv, w, 1'b0, 1'b0});
    endfunction

    // l1/l2 lift and swing, s1/s2 support
    function automatic void half_stride(leg_t l1, leg_t l2, leg_t s1, leg_t s2,
                                        bit fwd_l, bit fwd_r, bit side, logic [15:0] dly);
        logic [15:0] sh;
        logic [15:0] hf;
        sh = scaled_wait(dly, 24);
        hf = scaled_wait(dly, 2);
        add_step(l1, MV_COXA_UP, sh);
        add_step(l2, MV_COXA_UP, sh);
        add_step(s1, femur_move(s1, 1'b0, fwd_l, fwd_r, side), sh);
        add_step(s2, femur_move(s2, 1'b0, fwd_l, fwd_r, side), hf);
        add_step(l1, femur_move(l1, 1'b1, fwd_l, fwd_r, side), sh);
        add_step(l2, femur_move(l2, 1'b1, fwd_l, fwd_r, side), dly);
        add_step(l1, MV_COXA_DOWN, sh);
        add_step(l2, MV_COXA_DOWN, dly);
    endfunction

    function automatic void trot_cycle(bit fwd_l, bit fwd_r, bit side, logic [15:0] dly);
        half_stride(LEG_FR, LEG_BL, LEG_FL, LEG_BR, fwd_l, fwd_r, side, dly);
        half_stride(LEG_FL, LEG_BR, LEG_FR, LEG_BL, fwd_l, fwd_r, side, dly);
    endfunction

    function automatic void predict_command(logic [2:0] req, logic [15:0] dly);
        gait_step_t tail;
        case (req_t'(req))
            REQ_IDLE: begin
                for (int i = 0; i < 4; i++) begin
                    add_step(leg_t'(i), MV_COXA_DOWN, 16'd0);
                    add_step(leg_t'(i), MV_FEMUR_IDL, 16'd0);
                end
            end
            REQ_FWD:   trot_cycle(1'b1, 1'b1, 1'b0, dly);
            REQ_REV:   trot_cycle(1'b0, 1'b0, 1'b0, dly);
            REQ_LEFT:  trot_cycle(1'b1, 1'b1, 1'b1, dly);
            REQ_RIGHT: trot_cycle(1'b0, 1'b0, 1'b1, dly);
            REQ_ROT_L: begin
                trot_cycle(1'b1, 1'b0, 1'b1, dly);
                trot_cycle(1'b1, 1'b0, 1'b1, dly);
            end
            REQ_ROT_R: begin
                trot_cycle(1'b0, 1'b1, 1'b1, dly);
                trot_cycle(1'b0, 1'b1, 1'b1, dly);
            end
            default: begin
                // unknown command: lone error beat, tlast low
                steps_due.push_back('{LEG_FL, MV_COXA_UP, 16'd0, 1'b1, 1'b0});
                return;
            end
        endcase
        tail = steps_due.pop_back();
        tail.last = 1'b1;
        steps_due.push_back(tail);
    endfunction

    always @(posedge aclk) begin : watch
        gait_step_t due;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (steps_due.size() == 0) begin
                    err_total++;
                    if (err_total <= 10)
                        $display("unexpected result beat: leg %0d mv %0d wait %0d bad %0b last %0b",
                                 m_tdata[1:0], m_tdata[4:2], m_tdata[20:5], m_tuser, m_tlast);
                end else begin
                    due = steps_due.pop_front();
                    if (m_tdata[1:0] !== due.leg || m_tdata[4:2] !== due.mv ||
                        m_tdata[20:5] !== due.wait_ms || m_tuser !== due.bad ||
                        m_tlast !== due.last) begin
                        err_total++;
                        if (err_total <= 10) begin
                            $display("result mismatch: expected leg %0d mv %0d wait %0d bad %0b last %0b",
                                     due.leg, due.mv, due.wait_ms, due.bad, due.last);
                            $display("                 got      leg %0d mv %0d wait %0d bad %0b last %0b",
                                     m_tdata[1:0], m_tdata[4:2], m_tdata[20:5], m_tuser, m_tlast);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_command(s_tuser, s_tdata);
        end
        due_count = steps_due.size();
    end

endmodule

// File: verif/quadruped_gait_sequencer_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the gait sequencer: command stimulus, result backpressure, watchdog, verdict.
module quadruped_gait_sequencer_top_tb;
    import qgs_pkg::*;

    localparam int N_RANDOM       = 150;
    localparam int CALM_TAIL      = 30;
    localparam int HOLD_AT        = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int N_DIRECTED     = 21;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int mismatches;
    int outstanding;
    int quiet_cycles = 0;
    bit calm         = 1'b0;
    bit hold_req     = 1'b0;

    req_t        dir_req[N_DIRECTED] = '{
        REQ_IDLE, REQ_IDLE, REQ_FWD, REQ_FWD, REQ_FWD, REQ_FWD, REQ_REV, REQ_REV, REQ_REV,
        REQ_LEFT, REQ_LEFT, REQ_RIGHT, REQ_RIGHT, REQ_ROT_L, REQ_ROT_L, REQ_ROT_R, REQ_ROT_R,
        REQ_BAD, REQ_BAD, REQ_BAD, REQ_FWD};
    logic [15:0] dir_dly[N_DIRECTED] = '{
        16'h1234, 16'hFFFF, 16'd0, 16'd1, 16'd23, 16'd24, 16'd25, 16'd48, 16'd2,
        16'd47, 16'hFFFF, 16'd3, 16'd49, 16'd100, 16'd0, 16'hFFFF, 16'd1000,
        16'd0, 16'hFFFF, 16'h5A5A, 16'hFFFE};

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    quadruped_gait_sequencer_top #(.DELAY_WIDTH(16)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    quadruped_gait_sequencer_checker gait_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    task automatic send_command(input logic [2:0] req, input logic [15:0] dly);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= dly;
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    task automatic sender_gap();
        int n;
        if (!calm && $urandom_range(0, 2) == 0) begin
            n = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_delay();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'($urandom_range(0, 60));
            4: begin
                case ($urandom_range(0, 2))
                    0: return 16'd0;
                    1: return 16'd1;
                    default: return 16'hFFFF;
                endcase
            end
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin
        s_tvalid <= 1'b0;
        s_tdata  <= 16'd0;
        s_tuser  <= 3'd0;
        aresetn  <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_command(dir_req[i], dir_dly[i]);
            sender_gap();
        end
        drain_results();

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == HOLD_AT) hold_req = 1'b1;
            calm = (i >= N_RANDOM - CALM_TAIL);
            send_command(3'($urandom_range(0, 7)), pick_delay());
            sender_gap();
        end
        drain_results();
        repeat (20) @(posedge aclk);

        if (mismatches == 0 && outstanding == 0)
            $display("quadruped_gait_sequencer_top_tb: PASS");
        else
            $display("quadruped_gait_sequencer_top_tb: FAIL");
        $finish;
    end

    // result-side backpressure: random bursts plus one long hold-off
    initial begin
        int idle_left;
        int hold_left;
        bit hold_done;
        idle_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else if (calm) begin
                m_tready <= 1'b1;
            end else if (idle_left > 0) begin
                m_tready <= 1'b0;
                idle_left--;
            end else if ($urandom_range(0, 3) == 0) begin
                idle_left = $urandom_range(1, 9) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("quadruped_gait_sequencer_top_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// File: sim.f
rtl/qgs_pkg.sv
rtl/qgs_ctrl.sv
rtl/qgs_datapath.sv
rtl/quadruped_gait_sequencer_top.sv
verif/quadruped_gait_sequencer_checker.sv
verif/quadruped_gait_sequencer_top_tb.sv
